[hdl/ray_fan_segment_caster_macros.svh]
// Assertion macros for the ray fan caster. Bodies sample on clk, disabled in rst.
`ifndef RAY_FAN_SEGMENT_CASTER_MACROS_SVH
`define RAY_FAN_SEGMENT_CASTER_MACROS_SVH
`ifndef SYNTH
`define RFSC_CHECK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfsc check failed");
`define RFSC_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfsc check failed");
`else
`define RFSC_CHECK_SAME(lbl, ante, cons)
`define RFSC_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/rfsc_pkg.sv]
`default_nettype none
package rfsc_pkg;

  localparam int RAY_COUNT_DEF    = 90;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CRD = 24;  // stored coordinate width
  localparam int EW  = 26;  // edge corner width
  localparam int DW  = 27;  // coordinate difference width
  localparam int MW  = 33;  // multiplier operand width
  localparam int PW  = 66;  // product width
  localparam int AW  = 56;  // accumulator width
  localparam int CXW = 34;  // rotation datapath width
  localparam int FRAC = 24; // quotient bits of the wall fraction
  localparam int SW  = 5;   // step counter width

  localparam logic signed [CXW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [PW-1:0]  RND24 = 66'sd8388608;
  localparam logic signed [PW-1:0]  RND30 = 66'sd536870912;

  typedef enum logic [1:0] {OP_CAST, OP_WALL, OP_DETECT, OP_READ} op_t;

  typedef enum logic [1:0] {
    CFG_RAY_LENGTH, CFG_FAN_OFFSET, CFG_ANGLE_STEP, CFG_BOX_HALF
  } cfg_idx_t;

  typedef enum logic [3:0] {
    M_DEN1, M_DEN2, M_TN1, M_TN2, M_UN1, M_UN2,
    M_RX, M_RY, M_PX, M_PY, M_DX, M_DY, M_CX, M_CY
  } mstep_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CBEGIN, S_CINIT, S_CROT, S_CMUL, S_CWR,
    S_RD, S_RXY, S_EDGE, S_MULA, S_CHECK, S_DIV, S_MULB, S_DECIDE,
    S_RDIDX, S_OUT
  } state_t;

  typedef struct packed {
    logic          latch;
    logic          cast_begin;
    logic          cordic_init;
    logic          cordic_step;
    logic [SW-1:0] step;
    logic          mem_rd;
    logic          rd_idx;
    logic          mem_wr;
    logic          wr_hit;
    logic          load_rxy;
    logic          edge_load;
    logic [1:0]    edge_sel;
    logic          mul_go;
    mstep_t        mstep;
    logic          div_init;
    logic          div_step;
    logic          seen_set;
    logic          out_go;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cross_ok;
    logic hit;
  } stat_t;

  // Arctangent of 2^-i as a 32-bit turn fraction
  function automatic logic [31:0] atan_turn(input logic [SW-1:0] i);
    case (i)
      5'd0:    return 32'h20000000;
      5'd1:    return 32'h12E4051E;
      5'd2:    return 32'h09FB385B;
      5'd3:    return 32'h051111D4;
      5'd4:    return 32'h028B0D43;
      5'd5:    return 32'h0145D7E1;
      5'd6:    return 32'h00A2F61E;
      5'd7:    return 32'h00517C55;
      5'd8:    return 32'h0028BE53;
      5'd9:    return 32'h00145F2F;
      5'd10:   return 32'h000A2F98;
      5'd11:   return 32'h000517CC;
      5'd12:   return 32'h00028BE6;
      5'd13:   return 32'h000145F3;
      5'd14:   return 32'h0000A2FA;
      5'd15:   return 32'h0000517D;
      5'd16:   return 32'h000028BE;
      5'd17:   return 32'h0000145F;
      5'd18:   return 32'h00000A30;
      5'd19:   return 32'h00000518;
      5'd20:   return 32'h0000028C;
      5'd21:   return 32'h00000146;
      5'd22:   return 32'h000000A3;
      5'd23:   return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

  // Clamp to the signed 24-bit coordinate range
  function automatic logic signed [CRD-1:0] sat24(input logic signed [DW-1:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[CRD-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[hdl/ray_fan_segment_caster.sv]
`default_nettype none
// Ray fan caster. Pulse start with operation and its fields while busy is low;
// the request is taken at that edge and busy rises the next cycle. Exactly one
// result follows per request: done is high for one cycle with seen, end_x and
// end_y valid, and busy is already low in that cycle, so the next start may
// come at once. The receiver cannot stall; results are never held.
// Configuration: cfg_we writes cfg_data to register cfg_index at once; write
// only while busy is low. Operations:
//   begin cast: per ray, iterative rotation, then two products
//   wall: each ray gets a span test against the wall; each ray whose
//     span test passes also runs a 24-step divider plus six products
//   player detect: per ray a span test for each edge tried, plus the divider and
//     products for each passing edge; it stops at the first ray that sees the player
//   read ray: returns the endpoint of ray ray_index, zero when out of range
// All products go through one shared 33x33 multiplier, one a cycle.
// Reset restores the register defaults, puts the origin at zero and marks
// every endpoint as zero; no clearing pass is needed.
module ray_fan_segment_caster import rfsc_pkg::*; #(
  parameter int RAY_COUNT    = RAY_COUNT_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  output logic                       done,
  input  wire logic [1:0]            operation,
  input  wire logic signed [CRD-1:0] pos_x,
  input  wire logic signed [CRD-1:0] pos_y,
  input  wire logic [15:0]           heading,
  input  wire logic signed [CRD-1:0] wall_ax,
  input  wire logic signed [CRD-1:0] wall_ay,
  input  wire logic signed [CRD-1:0] wall_bx,
  input  wire logic signed [CRD-1:0] wall_by,
  input  wire logic [7:0]            ray_index,
  output logic                       seen,
  output logic signed [CRD-1:0]      end_x,
  output logic signed [CRD-1:0]      end_y,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [22:0]           cfg_data
);

  localparam int RIW = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;

  cmd_t           cmd;
  stat_t          stat;
  logic [RIW-1:0] ray_sel;

  rfsc_ctrl #(
    .RAY_COUNT    (RAY_COUNT),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .stat    (stat),
    .cmd     (cmd),
    .ray_sel (ray_sel),
    .busy    (busy)
  );

  rfsc_dpath #(
    .RAY_COUNT (RAY_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ray_sel   (ray_sel),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operation (operation),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading),
    .wall_ax   (wall_ax),
    .wall_ay   (wall_ay),
    .wall_bx   (wall_bx),
    .wall_by   (wall_by),
    .ray_index (ray_index),
    .done      (done),
    .seen      (seen),
    .end_x     (end_x),
    .end_y     (end_y)
  );

`include "ray_fan_segment_caster_macros.svh"

  // result only appears once the sequencer is back to idle
  `RFSC_CHECK_SAME(a_done_idle, done, !busy)
  // a taken request occupies the block on the next cycle
  `RFSC_CHECK_NEXT(a_start_busy, start && !busy, busy)
  // a taken request never answers on the very next cycle
  `RFSC_CHECK_NEXT(a_no_instant, start && !busy, !done)
  // endpoint writes happen only inside a request
  `RFSC_CHECK_SAME(a_wr_busy, cmd.mem_wr, busy)

endmodule
`default_nettype wire

[hdl/rfsc_ctrl.sv]
`default_nettype none
module rfsc_ctrl import rfsc_pkg::*; #(
  parameter int RAY_COUNT    = RAY_COUNT_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  localparam int RIW = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire stat_t          stat,
  output cmd_t                cmd,
  output logic [RIW-1:0]      ray_sel,
  output logic                busy
);

  localparam logic [RIW-1:0] LAST_RAY  = RIW'(RAY_COUNT - 1);
  localparam logic [SW-1:0]  LAST_ROT  = SW'(CORDIC_STEPS - 1);
  localparam logic [SW-1:0]  LAST_DIV  = SW'(FRAC - 1);
  localparam logic [SW-1:0]  MUL_DRAIN = SW'(6);

  state_t         state, state_next;
  logic [SW-1:0]  cnt, cnt_next;
  logic [RIW-1:0] ray_k, ray_k_next;
  logic [1:0]     edge_n, edge_n_next;
  logic           adv;

  function automatic mstep_t span_step(input logic [SW-1:0] c);
    case (c)
      5'd0:    return M_DEN1;
      5'd1:    return M_DEN2;
      5'd2:    return M_TN1;
      5'd3:    return M_TN2;
      5'd4:    return M_UN1;
      default: return M_UN2;
    endcase
  endfunction

  function automatic mstep_t point_step(input logic [SW-1:0] c);
    case (c)
      5'd0:    return M_RX;
      5'd1:    return M_RY;
      5'd2:    return M_PX;
      5'd3:    return M_PY;
      5'd4:    return M_DX;
      default: return M_DY;
    endcase
  endfunction

  // Hold state, step counter, ray and edge counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      ray_k  <= '0;
      edge_n <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      ray_k  <= ray_k_next;
      edge_n <= edge_n_next;
    end
  end

  // Sequence each request through the datapath
  always_comb begin
    cmd         = '0;
    state_next  = state;
    cnt_next    = cnt;
    ray_k_next  = ray_k;
    edge_n_next = edge_n;
    adv         = 1'b0;
    cmd.step     = cnt;
    cmd.edge_sel = edge_n;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        ray_k_next = '0;
        case (stat.op)
          OP_CAST: state_next = S_CBEGIN;
          OP_READ: state_next = S_RDIDX;
          default: state_next = S_RD;
        endcase
      end
      S_CBEGIN: begin
        cmd.cast_begin = 1'b1;
        state_next     = S_CINIT;
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_next        = '0;
        state_next      = S_CROT;
      end
      S_CROT: begin
        cmd.cordic_step = 1'b1;
        if (cnt == LAST_ROT) begin
          cnt_next   = '0;
          state_next = S_CMUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CMUL: begin
        if (cnt < SW'(2)) begin
          cmd.mul_go = 1'b1;
          cmd.mstep  = (cnt == '0) ? M_CX : M_CY;
        end
        if (cnt == SW'(2)) begin
          cnt_next   = '0;
          state_next = S_CWR;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CWR: begin
        cmd.mem_wr = 1'b1;
        if (ray_k == LAST_RAY) begin
          state_next = S_OUT;
        end else begin
          ray_k_next = ray_k + 1'b1;
          state_next = S_CINIT;
        end
      end
      S_RD: begin
        cmd.mem_rd  = 1'b1;
        edge_n_next = '0;
        state_next  = S_RXY;
      end
      S_RXY: begin
        cmd.load_rxy = 1'b1;
        state_next   = S_EDGE;
      end
      S_EDGE: begin
        cmd.edge_load = 1'b1;
        cnt_next      = '0;
        state_next    = S_MULA;
      end
      S_MULA: begin
        if (cnt < MUL_DRAIN) begin
          cmd.mul_go = 1'b1;
          cmd.mstep  = span_step(cnt);
        end
        if (cnt == MUL_DRAIN) begin
          cnt_next   = '0;
          state_next = S_CHECK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.cross_ok) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          adv = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == LAST_DIV) begin
          cnt_next   = '0;
          state_next = S_MULB;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MULB: begin
        if (cnt < MUL_DRAIN) begin
          cmd.mul_go = 1'b1;
          cmd.mstep  = point_step(cnt);
        end
        if (cnt == MUL_DRAIN) begin
          cnt_next   = '0;
          state_next = S_DECIDE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DECIDE: begin
        if (stat.hit && stat.op == OP_DETECT) begin
          cmd.seen_set = 1'b1;
          state_next   = S_OUT;
        end else begin
          if (stat.hit) begin
            cmd.mem_wr = 1'b1;
            cmd.wr_hit = 1'b1;
          end
          adv = 1'b1;
        end
      end
      S_RDIDX: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_idx = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_go = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    // Advance to the next edge of the square or the next ray
    if (adv) begin
      if (stat.op == OP_DETECT && edge_n != 2'd3) begin
        edge_n_next = edge_n + 1'b1;
        state_next  = S_EDGE;
      end else if (ray_k == LAST_RAY) begin
        state_next = S_OUT;
      end else begin
        ray_k_next = ray_k + 1'b1;
        state_next = S_RD;
      end
    end
  end

  assign ray_sel = ray_k;
  assign busy    = (state != S_IDLE);

endmodule
`default_nettype wire

[hdl/rfsc_dpath.sv]
`default_nettype none
module rfsc_dpath import rfsc_pkg::*; #(
  parameter int RAY_COUNT = RAY_COUNT_DEF,
  localparam int RIW = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  input  wire logic [RIW-1:0]        ray_sel,
  output stat_t                      stat,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [22:0]           cfg_data,
  input  wire logic [1:0]            operation,
  input  wire logic signed [CRD-1:0] pos_x,
  input  wire logic signed [CRD-1:0] pos_y,
  input  wire logic [15:0]           heading,
  input  wire logic signed [CRD-1:0] wall_ax,
  input  wire logic signed [CRD-1:0] wall_ay,
  input  wire logic signed [CRD-1:0] wall_bx,
  input  wire logic signed [CRD-1:0] wall_by,
  input  wire logic [7:0]            ray_index,
  output logic                       done,
  output logic                       seen,
  output logic signed [CRD-1:0]      end_x,
  output logic signed [CRD-1:0]      end_y
);

  // configuration
  logic [22:0] ray_len;
  logic [15:0] fan_off, ang_step, box_half;

  // latched request
  op_t                  op_r;
  logic signed [CRD-1:0] in_px, in_py, w_ax, w_ay, w_bx, w_by;
  logic [15:0]          heading_r;
  logic [7:0]           idx_r;

  // fan origin and angle walk
  logic signed [CRD-1:0] ox, oy;
  logic [15:0]           angle;

  // rotation unit
  logic signed [CXW-1:0] cx, cy, cz;
  logic                  flip;
  logic [31:0]           z32;
  logic signed [CXW-1:0] atn, cneg, sneg;

  // endpoint store
  logic [2*CRD-1:0] mem [RAY_COUNT];
  logic [2*CRD-1:0] q;
  logic             q_vld;
  logic [RAY_COUNT-1:0] vld;
  logic [RIW-1:0]   raddr;
  logic [2*CRD-1:0] wdata;
  logic signed [CRD-1:0] ex, ey;
  logic             in_range;

  // crossing test
  logic signed [CRD:0]   rx, ry;
  logic signed [EW-1:0]  e_x1, e_y1, e_x2, e_y2;
  logic signed [EW-1:0]  px26, py26, h26, lo_x, hi_x, lo_y, hi_y;
  logic signed [DW-1:0]  dxw, dyw, axo, ayo, bxa, bya, dpx, dpy, ox_w, oy_w;
  logic signed [EW-1:0]  hpx, hpy;
  logic signed [CRD-1:0] endx_c, endy_c;
  logic signed [AW-1:0]  den, tn, un, hit_dist, rdist, tabs, dabs;
  logic                  den_pos;

  // shared multiplier
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod, r24, r30;
  logic signed [DW-1:0] c_off;
  mstep_t               ms_d;
  logic                 mv_d;

  // divider
  logic [AW:0]     dn, n2;
  logic [AW-1:0]   dd;
  logic [FRAC-1:0] tf;

  logic seen_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_len  <= 23'd128000;
      fan_off  <= 16'd4096;
      ang_step <= 16'd91;
      box_half <= 16'd1664;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RAY_LENGTH: ray_len  <= cfg_data;
        CFG_FAN_OFFSET: fan_off  <= cfg_data[15:0];
        CFG_ANGLE_STEP: ang_step <= cfg_data[15:0];
        CFG_BOX_HALF:   box_half <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r      <= op_t'(operation);
      in_px     <= pos_x;
      in_py     <= pos_y;
      heading_r <= heading;
      w_ax      <= wall_ax;
      w_ay      <= wall_ay;
      w_bx      <= wall_bx;
      w_by      <= wall_by;
      idx_r     <= ray_index;
    end
  end

  // Set origin at cast, step the ray angle after each cast endpoint write
  always_ff @(posedge clk) begin
    if (rst) begin
      ox <= '0;
      oy <= '0;
    end else if (cmd.cast_begin) begin
      ox <= in_px;
      oy <= in_py;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cast_begin) begin
      angle <= heading_r - fan_off;
    end else if (cmd.mem_wr && !cmd.wr_hit) begin
      angle <= angle + ang_step;
    end
  end

  // Rotate toward the ray angle, one micro-rotation a cycle
  always_comb begin
    z32 = {angle, 16'h0000};
    if (angle[15:14] == 2'b01 || angle[15:14] == 2'b10) begin
      z32 = z32 + 32'h80000000;
    end
    atn  = CXW'($signed({1'b0, atan_turn(cmd.step)}));
    cneg = -cx;
    sneg = -cy;
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx   <= CORDIC_GAIN;
      cy   <= '0;
      cz   <= CXW'($signed(z32));
      flip <= (angle[15:14] == 2'b01 || angle[15:14] == 2'b10);
    end else if (cmd.cordic_step) begin
      if (!cz[CXW-1]) begin
        cx <= cx - (cy >>> cmd.step);
        cy <= cy + (cx >>> cmd.step);
        cz <= cz - atn;
      end else begin
        cx <= cx + (cy >>> cmd.step);
        cy <= cy - (cx >>> cmd.step);
        cz <= cz + atn;
      end
    end
  end

  // Endpoint store: one write and one registered read port
  assign raddr = cmd.rd_idx ? idx_r[RIW-1:0] : ray_sel;
  assign wdata = cmd.wr_hit ? {hpy[CRD-1:0], hpx[CRD-1:0]} : {endy_c, endx_c};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[ray_sel] <= wdata;
    end
    if (cmd.mem_rd) begin
      q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (cmd.mem_wr) begin
        vld[ray_sel] <= 1'b1;
      end
      if (cmd.mem_rd) begin
        q_vld <= vld[raddr];
      end
    end
  end

  assign ex       = q_vld ? $signed(q[CRD-1:0]) : '0;
  assign ey       = q_vld ? $signed(q[2*CRD-1:CRD]) : '0;
  assign in_range = ({1'b0, idx_r} < 9'(RAY_COUNT));

  // Load ray vector and edge corners
  always_comb begin
    px26 = EW'(in_px);
    py26 = EW'(in_py);
    h26  = $signed({{(EW-16){1'b0}}, box_half});
    lo_x = px26 - h26;
    hi_x = px26 + h26;
    lo_y = py26 - h26;
    hi_y = py26 + h26;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rxy) begin
      rx <= (CRD+1)'(ox) - (CRD+1)'(ex);
      ry <= (CRD+1)'(oy) - (CRD+1)'(ey);
    end
    if (cmd.edge_load) begin
      if (op_r == OP_WALL) begin
        e_x1 <= EW'(w_ax);
        e_y1 <= EW'(w_ay);
        e_x2 <= EW'(w_bx);
        e_y2 <= EW'(w_by);
      end else begin
        case (cmd.edge_sel)
          2'd0: begin
            e_x1 <= lo_x; e_y1 <= lo_y; e_x2 <= hi_x; e_y2 <= lo_y;
          end
          2'd1: begin
            e_x1 <= lo_x; e_y1 <= lo_y; e_x2 <= lo_x; e_y2 <= hi_y;
          end
          2'd2: begin
            e_x1 <= hi_x; e_y1 <= hi_y; e_x2 <= lo_x; e_y2 <= hi_y;
          end
          default: begin
            e_x1 <= hi_x; e_y1 <= hi_y; e_x2 <= hi_x; e_y2 <= lo_y;
          end
        endcase
      end
    end
  end

  // Differences feeding the multiplier
  always_comb begin
    ox_w = DW'(ox);
    oy_w = DW'(oy);
    dxw  = DW'(e_x1) - DW'(e_x2);
    dyw  = DW'(e_y1) - DW'(e_y2);
    axo  = DW'(e_x1) - ox_w;
    ayo  = DW'(e_y1) - oy_w;
    bxa  = DW'(e_x2) - DW'(e_x1);
    bya  = DW'(e_y2) - DW'(e_y1);
    dpx  = ox_w - DW'(hpx);
    dpy  = oy_w - DW'(hpy);
  end

  // Select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mstep)
      M_DEN1: begin ma = MW'(dxw); mb = MW'(ry);  end
      M_DEN2: begin ma = MW'(dyw); mb = MW'(rx);  end
      M_TN1:  begin ma = MW'(axo); mb = MW'(ry);  end
      M_TN2:  begin ma = MW'(ayo); mb = MW'(rx);  end
      M_UN1:  begin ma = MW'(dyw); mb = MW'(axo); end
      M_UN2:  begin ma = MW'(dxw); mb = MW'(ayo); end
      M_RX:   begin ma = MW'(rx);  mb = MW'(rx);  end
      M_RY:   begin ma = MW'(ry);  mb = MW'(ry);  end
      M_PX:   begin ma = MW'(bxa); mb = $signed({{(MW-FRAC){1'b0}}, tf}); end
      M_PY:   begin ma = MW'(bya); mb = $signed({{(MW-FRAC){1'b0}}, tf}); end
      M_DX:   begin ma = MW'(dpx); mb = MW'(dpx); end
      M_DY:   begin ma = MW'(dpy); mb = MW'(dpy); end
      M_CX: begin
        ma = $signed({{(MW-23){1'b0}}, ray_len});
        mb = flip ? MW'(cneg) : MW'(cx);
      end
      M_CY: begin
        ma = $signed({{(MW-23){1'b0}}, ray_len});
        mb = flip ? MW'(sneg) : MW'(cy);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    ms_d <= cmd.mstep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv_d <= 1'b0;
    end else begin
      mv_d <= cmd.mul_go;
    end
  end

  // Round and scale products
  always_comb begin
    r24   = (prod + RND24) >>> 24;
    r30   = (prod + RND30) >>> 30;
    c_off = DW'(r30);
  end

  // Accumulate the product issued in the previous cycle
  always_ff @(posedge clk) begin
    if (mv_d) begin
      case (ms_d)
        M_DEN1: den      <= AW'(prod);
        M_DEN2: den      <= den - AW'(prod);
        M_TN1:  tn       <= AW'(prod);
        M_TN2:  tn       <= tn - AW'(prod);
        M_UN1:  un       <= AW'(prod);
        M_UN2:  un       <= un - AW'(prod);
        M_RX:   rdist    <= AW'(prod);
        M_RY:   rdist    <= rdist + AW'(prod);
        M_PX:   hpx      <= e_x1 + EW'(r24);
        M_PY:   hpy      <= e_y1 + EW'(r24);
        M_DX:   hit_dist <= AW'(prod);
        M_DY:   hit_dist <= hit_dist + AW'(prod);
        M_CX:   endx_c   <= sat24(ox_w + c_off);
        M_CY:   endy_c   <= sat24(oy_w + c_off);
        default: ;
      endcase
    end
  end

  // Span test on wall and ray
  always_comb begin
    den_pos = !den[AW-1];
    tabs    = den_pos ? tn : -tn;
    dabs    = den_pos ? den : -den;
    stat.op = op_r;
    if (den == '0) begin
      stat.cross_ok = 1'b0;
    end else if (den_pos) begin
      stat.cross_ok = (tn > 0) && (tn < den) && (un > 0);
    end else begin
      stat.cross_ok = (tn < 0) && (tn > den) && (un < 0);
    end
    stat.hit = (hit_dist < rdist);
  end

  // Restoring division: one fraction bit a cycle
  assign n2 = {dn[AW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dn <= {1'b0, tabs};
      dd <= dabs;
      tf <= '0;
    end else if (cmd.div_step) begin
      if (n2 >= {1'b0, dd}) begin
        dn <= n2 - {1'b0, dd};
        tf <= {tf[FRAC-2:0], 1'b1};
      end else begin
        dn <= n2;
        tf <= {tf[FRAC-2:0], 1'b0};
      end
    end
  end

  // Track player sighting
  always_ff @(posedge clk) begin
    if (rst || cmd.latch) begin
      seen_r <= 1'b0;
    end else if (cmd.seen_set) begin
      seen_r <= 1'b1;
    end
  end

  // Drive the result strobe and fields
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_go) begin
      seen  <= (op_r == OP_DETECT) && seen_r;
      end_x <= (op_r == OP_READ && in_range) ? ex : '0;
      end_y <= (op_r == OP_READ && in_range) ? ey : '0;
    end
  end

endmodule
`default_nettype wire

[sim/ray_fan_checker.sv]
`default_nettype none
// Watches the request and result channels of the ray fan caster, predicts every
// result from its own copy of the rays and registers, and compares in order.
module ray_fan_checker import rfsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic                  done,
  input  wire logic [1:0]            operation,
  input  wire logic signed [CRD-1:0] pos_x,
  input  wire logic signed [CRD-1:0] pos_y,
  input  wire logic [15:0]           heading,
  input  wire logic signed [CRD-1:0] wall_ax,
  input  wire logic signed [CRD-1:0] wall_ay,
  input  wire logic signed [CRD-1:0] wall_bx,
  input  wire logic signed [CRD-1:0] wall_by,
  input  wire logic [7:0]            ray_index,
  input  wire logic                  seen,
  input  wire logic signed [CRD-1:0] end_x,
  input  wire logic signed [CRD-1:0] end_y,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [22:0]           cfg_data,
  output int                         failures,
  output int                         outstanding
);

  localparam int NRAYS = RAY_COUNT_DEF;
  localparam int NSTEPS = CORDIC_STEPS_DEF;
  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;

  typedef struct {
    logic                  seen;
    logic signed [CRD-1:0] ex;
    logic signed [CRD-1:0] ey;
  } outcome_t;

  // Arctangent of 2^-i, 32-bit turn fraction
  localparam logic [31:0] ARC [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic [22:0] len_q;
  logic [15:0] fan_off_q;
  logic [15:0] step_q;
  logic [15:0] half_q;
  longint      org_x, org_y;
  longint      tip_x [NRAYS];
  longint      tip_y [NRAYS];
  outcome_t    owed [$];

  function automatic longint clamp24(input longint v);
    if (v > SAT_HI) begin
      return SAT_HI;
    end else if (v < SAT_LO) begin
      return SAT_LO;
    end
    return v;
  endfunction

  // Rotate the unit vector to a turn angle; cos and sin come back in Q30
  function automatic void unit_dir(input logic [15:0] ang, output longint c,
                                   output longint s);
    logic [31:0] z32;
    longint      z, x, y, nx;
    bit          flip;
    z32 = {ang, 16'h0000};
    flip = (z32[31:30] == 2'd1) || (z32[31:30] == 2'd2);
    if (flip) begin
      z32 = z32 + 32'h80000000;
    end
    z = longint'($signed(z32));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < NSTEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ARC[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ARC[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Segment (x1,y1)-(x2,y2) against the ray to (ex,ey); true with the
  // crossing point when it lies strictly nearer than the current tip
  function automatic bit seg_clip(input longint x1, y1, x2, y2, ex, ey,
                                  output longint hx, output longint hy);
    longint den, tn, un, n, d, tf, px, py, dx, dy, rx, ry;
    den = (x1 - x2) * (org_y - ey) - (y1 - y2) * (org_x - ex);
    tn = (x1 - org_x) * (org_y - ey) - (y1 - org_y) * (org_x - ex);
    un = -((x1 - x2) * (y1 - org_y) - (y1 - y2) * (x1 - org_x));
    hx = 0;
    hy = 0;
    if (den == 0) return 0;
    if (den > 0) begin
      if (!(tn > 0 && tn < den && un > 0)) return 0;
      n = tn;
      d = den;
    end else begin
      if (!(tn < 0 && tn > den && un < 0)) return 0;
      n = -tn;
      d = -den;
    end
    tf = 0;
    for (int i = 0; i < 24; i++) begin
      n = n <<< 1;
      tf = tf <<< 1;
      if (n >= d) begin
        n = n - d;
        tf = tf | 1;
      end
    end
    px = x1 + ((tf * (x2 - x1) + 64'sd8388608) >>> 24);
    py = y1 + ((tf * (y2 - y1) + 64'sd8388608) >>> 24);
    dx = org_x - px;
    dy = org_y - py;
    rx = org_x - ex;
    ry = org_y - ey;
    if (dx * dx + dy * dy < rx * rx + ry * ry) begin
      hx = px;
      hy = py;
      return 1;
    end
    return 0;
  endfunction

  // Advance the ray state by one request and return what the block owes
  function automatic outcome_t predict_request(input op_t op);
    outcome_t    r;
    logic [15:0] base, ang;
    longint      c, s, hx, hy, h, qx, qy, ex, ey;
    r.seen = 1'b0;
    r.ex = '0;
    r.ey = '0;
    qx = longint'(pos_x);
    qy = longint'(pos_y);
    case (op)
      OP_CAST: begin
        base = heading - fan_off_q;
        org_x = qx;
        org_y = qy;
        for (int k = 0; k < NRAYS; k++) begin
          ang = base + 16'(k) * step_q;
          unit_dir(ang, c, s);
          tip_x[k] = clamp24(org_x + ((longint'(len_q) * c + 64'sd536870912) >>> 30));
          tip_y[k] = clamp24(org_y + ((longint'(len_q) * s + 64'sd536870912) >>> 30));
        end
      end
      OP_WALL: begin
        for (int k = 0; k < NRAYS; k++) begin
          if (seg_clip(longint'(wall_ax), longint'(wall_ay), longint'(wall_bx),
                       longint'(wall_by), tip_x[k], tip_y[k], hx, hy)) begin
            tip_x[k] = hx;
            tip_y[k] = hy;
          end
        end
      end
      OP_DETECT: begin
        h = longint'(half_q);
        for (int k = 0; k < NRAYS && !r.seen; k++) begin
          ex = tip_x[k];
          ey = tip_y[k];
          if (seg_clip(qx - h, qy - h, qx + h, qy - h, ex, ey, hx, hy) ||
              seg_clip(qx - h, qy - h, qx - h, qy + h, ex, ey, hx, hy) ||
              seg_clip(qx + h, qy + h, qx - h, qy + h, ex, ey, hx, hy) ||
              seg_clip(qx + h, qy + h, qx + h, qy - h, ex, ey, hx, hy)) begin
            r.seen = 1'b1;
          end
        end
      end
      default: begin
        if (ray_index < NRAYS) begin
          r.ex = tip_x[ray_index][CRD-1:0];
          r.ey = tip_y[ray_index][CRD-1:0];
        end
      end
    endcase
    return r;
  endfunction

  // Track registers, take requests, compare results
  always @(posedge clk) begin
    outcome_t want;
    int       bad;
    bad = 0;
    if (rst) begin
      len_q <= 23'd128000;
      fan_off_q <= 16'd4096;
      step_q <= 16'd91;
      half_q <= 16'd1664;
      org_x = 0;
      org_y = 0;
      for (int k = 0; k < NRAYS; k++) begin
        tip_x[k] = 0;
        tip_y[k] = 0;
      end
      owed.delete();
      failures <= 0;
      outstanding <= 0;
    end else begin
      if (done) begin
        if (owed.size() == 0) begin
          $error("result with no request waiting");
          bad = bad + 1;
        end else begin
          want = owed.pop_front();
          if (seen !== want.seen) begin
            $error("seen: expected %0d, got %0d", want.seen, seen);
            bad = bad + 1;
          end
          if (end_x !== want.ex) begin
            $error("end_x: expected %0d, got %0d", want.ex, end_x);
            bad = bad + 1;
          end
          if (end_y !== want.ey) begin
            $error("end_y: expected %0d, got %0d", want.ey, end_y);
            bad = bad + 1;
          end
        end
      end
      if (start && !busy) begin
        owed.insert(owed.size(), predict_request(op_t'(operation)));
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RAY_LENGTH: len_q <= cfg_data;
          CFG_FAN_OFFSET: fan_off_q <= cfg_data[15:0];
          CFG_ANGLE_STEP: step_q <= cfg_data[15:0];
          CFG_BOX_HALF:   half_q <= cfg_data[15:0];
          default: ;
        endcase
      end
      failures <= failures + bad;
      outstanding <= owed.size();
    end
  end

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
  import rfsc_pkg::*;

  localparam longint CYCLE_LIMIT = 100000000;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy, done, seen;
  logic [1:0]            operation = '0;
  logic signed [CRD-1:0] pos_x = '0, pos_y = '0;
  logic [15:0]           heading = '0;
  logic signed [CRD-1:0] wall_ax = '0, wall_ay = '0, wall_bx = '0, wall_by = '0;
  logic [7:0]            ray_index = '0;
  logic signed [CRD-1:0] end_x, end_y;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [22:0]           cfg_data = '0;
  int                    failures, outstanding;
  longint                cycles = 0;
  int                    center_x, center_y;
  bit                    calm;

  ray_fan_segment_caster dut (.*);

  ray_fan_checker watch (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one request once the block is free; called at a falling edge
  task automatic issue(input op_t op, input int px, input int py,
                       input int hd, input int ax, input int ay,
                       input int bx, input int by, input int idx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    while (busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    operation = op;
    pos_x = px[CRD-1:0];
    pos_y = py[CRD-1:0];
    heading = hd[15:0];
    wall_ax = ax[CRD-1:0];
    wall_ay = ay[CRD-1:0];
    wall_bx = bx[CRD-1:0];
    wall_by = by[CRD-1:0];
    ray_index = idx[7:0];
    start = 1'b1;
    @(negedge clk);
  endtask

  // Hold until every result is back, then let the block settle
  task automatic drain();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[22:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int near(input int c, input int span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly requests around the agent, some full-range noise
  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      center_x = near(0, 60000);
      center_y = near(0, 60000);
      issue(OP_CAST, center_x, center_y, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom);
    end else if (pick < 40) begin
      issue(OP_WALL, $urandom, $urandom, $urandom, near(center_x, 50000),
            near(center_y, 50000), near(center_x, 50000), near(center_y, 50000),
            $urandom);
    end else if (pick < 55) begin
      issue(OP_DETECT, near(center_x, 40000), near(center_y, 40000), $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 90) begin
      issue(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom_range(0, 99) < 85 ? $urandom_range(0, 89) : $urandom);
    end else begin
      issue(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    center_x = 0;
    center_y = 0;
    calm = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: reads, a wall and a detect before any cast, then a fan at the origin
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 89);
    issue(OP_WALL, 0, 0, 0, 5000, -50000, 5000, 50000, 0);
    issue(OP_DETECT, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_CAST, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 45);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 90);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 255);
    issue(OP_WALL, 0, 0, 0, 5000, -50000, 5000, 50000, 0);
    issue(OP_WALL, 0, 0, 0, 3000, 3000, 3000, 3000, 0);
    issue(OP_WALL, 0, 0, 0, 20000, 0, 30000, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 45);
    issue(OP_DETECT, 2000, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_DETECT, 0, -100000, 0, 0, 0, 0, 0, 0);
    issue(OP_CAST, 8388607, -8388608, 65535, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 89);
    issue(OP_WALL, 0, 0, 0, 8388607, -8388608, -8388608, 8388607, 0);
    issue(OP_CAST, -8388608, 8388607, 32768, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 10);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: ;
        1: begin
          write_reg(CFG_RAY_LENGTH, 8388607);
          write_reg(CFG_FAN_OFFSET, 0);
          write_reg(CFG_ANGLE_STEP, 65535);
          write_reg(CFG_BOX_HALF, 0);
        end
        2: begin
          write_reg(CFG_RAY_LENGTH, 0);
          write_reg(CFG_FAN_OFFSET, 65535);
          write_reg(CFG_ANGLE_STEP, 0);
          write_reg(CFG_BOX_HALF, 65535);
        end
        3: begin
          write_reg(CFG_RAY_LENGTH, 25600);
          write_reg(CFG_FAN_OFFSET, 16384);
          write_reg(CFG_ANGLE_STEP, 728);
          write_reg(CFG_BOX_HALF, 2560);
        end
        default: begin
          write_reg(CFG_RAY_LENGTH, $urandom_range(0, 200000));
          write_reg(CFG_FAN_OFFSET, $urandom_range(0, 65535));
          write_reg(CFG_ANGLE_STEP, $urandom_range(0, 1000));
          write_reg(CFG_BOX_HALF, $urandom_range(0, 8000));
        end
      endcase
      calm = (p % 3 == 0);
      center_x = near(0, 30000);
      center_y = near(0, 30000);
      issue(OP_CAST, center_x, center_y, $urandom, 0, 0, 0, 0, 0);
      for (int n = 0; n < PER_PHASE; n++) begin
        // Let the block run dry once mid-phase
        if (n == PER_PHASE / 2) begin
          drain();
        end
        random_request();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
